[sv/button_chatter_recontact_filter_defines.svh]
// Assertion macros for the button chatter and recontact filter.
// Used by files that assert; expects clk and rst_n in scope.
`ifndef BUTTON_CHATTER_RECONTACT_FILTER_DEFINES_SVH
`define BUTTON_CHATTER_RECONTACT_FILTER_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define BCRF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcrf: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define BCRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcrf: next-cycle check failed");

`else

`define BCRF_ASSERT_SAME(label, ante, cons)
`define BCRF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[sv/bcrf_pkg.sv]
// Package for the button chatter and recontact filter.
// Types and constants shared by the interfaces, config block and top level.
`default_nettype none

package bcrf_pkg;

    localparam int CFG_W     = 10;  // width of the time thresholds
    localparam int CFG_IDX_W = 2;
    localparam int OP_W      = 2;

    localparam logic [CFG_W-1:0] CHATTER_RESET   = 10'd100;
    localparam logic [CFG_W-1:0] RECONTACT_RESET = 10'd30;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_DOWN  = 2'd1,
        OP_UP    = 2'd2,
        OP_OTHER = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHATTER   = 2'd0,
        REG_RECONTACT = 2'd1,
        REG_BYPASS    = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] chatter_time;
        logic [CFG_W-1:0] recontact_time;
        logic             bypass;
    } cfg_t;

endpackage

`default_nettype wire

[sv/bcrf_if.sv]
// Channel interfaces for the button chatter and recontact filter.
// Depends on bcrf_pkg for widths.
`default_nettype none

interface bcrf_evt_if;
    logic                        valid;
    logic                        ready;
    logic [bcrf_pkg::OP_W-1:0]   op;
    logic                        injected;

    modport source (output valid, output op, output injected, input ready);
    modport sink   (input valid, input op, input injected, output ready);
endinterface

interface bcrf_res_if;
    logic valid;
    logic ready;
    logic forward;
    logic release_now;
    logic held;

    modport source (output valid, output forward, output release_now, output held,
                    input ready);
    modport sink   (input valid, input forward, input release_now, input held,
                    output ready);
endinterface

interface bcrf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bcrf_pkg::CFG_IDX_W-1:0]   index;
    logic [bcrf_pkg::CFG_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/bcrf_cfg.sv]
// Configuration register file for the button chatter and recontact filter.
// Depends on bcrf_pkg and bcrf_cfg_if.
`default_nettype none

module bcrf_cfg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    bcrf_cfg_if.sink           cfg,
    output bcrf_pkg::cfg_t     regs
);

    bcrf_pkg::cfg_t regs_reg;
    bcrf_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (bcrf_pkg::reg_idx_t'(cfg.index))
                bcrf_pkg::REG_CHATTER:   regs_next.chatter_time   = cfg.data;
                bcrf_pkg::REG_RECONTACT: regs_next.recontact_time = cfg.data;
                bcrf_pkg::REG_BYPASS:    regs_next.bypass         = cfg.data[0];
                default:                 regs_next = regs_reg;  // unused index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.chatter_time   <= bcrf_pkg::CHATTER_RESET;
            regs_reg.recontact_time <= bcrf_pkg::RECONTACT_RESET;
            regs_reg.bypass         <= 1'b0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

[sv/button_chatter_recontact_filter.sv]
// Top level of the button chatter and recontact filter.
// Depends on bcrf_pkg, the bcrf interfaces, bcrf_cfg and the assertion macro header.
//
//  channel | dir | payload                       | transfer when
//  --------+-----+-------------------------------+------------------------
//  ev      | in  | op, injected                  | ev.valid && ev.ready
//  res     | out | forward, release_now, held    | res.valid && res.ready
//  cfg     | in  | index, data                   | cfg.valid && cfg.ready
//
// One item per cycle unless res stalls: each transfer on ev is decided in the
// cycle it arrives and its result lands in the output register on the same edge.
// ev.ready is high whenever the output register is empty or being emptied,
// so a stalled res holds exactly one result and back-pressures ev.
// cfg is always ready. rst_n clears state, counters and config to defaults.
`default_nettype none
`include "button_chatter_recontact_filter_defines.svh"

module button_chatter_recontact_filter #(
    parameter int TIME_BITS = 10
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    bcrf_evt_if.sink     ev,
    bcrf_res_if.source   res,
    bcrf_cfg_if.sink     cfg
);

    // compare width covers both counter and threshold
    localparam int CMP_W = (TIME_BITS > bcrf_pkg::CFG_W) ? TIME_BITS : bcrf_pkg::CFG_W;

    bcrf_pkg::cfg_t regs;

    bcrf_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // filter state
    logic                 pressed_reg,       pressed_next;
    logic                 pending_reg,       pending_next;
    logic [TIME_BITS-1:0] since_press_reg,   since_press_next;
    logic [TIME_BITS-1:0] since_release_reg, since_release_next;

    // output register
    logic res_valid_reg,   res_valid_next;
    logic forward_reg,     forward_next;
    logic release_reg,     release_next;
    logic held_reg,        held_next;

    logic                 accept;
    logic [TIME_BITS-1:0] press_inc;
    logic [TIME_BITS-1:0] release_inc;

    assign ev.ready = !res_valid_reg || res.ready;
    assign accept   = ev.valid && ev.ready;

    assign res.valid       = res_valid_reg;
    assign res.forward     = forward_reg;
    assign res.release_now = release_reg;
    assign res.held        = held_reg;

    // saturating increments
    assign press_inc   = (&since_press_reg)   ? since_press_reg   : since_press_reg + 1'b1;
    assign release_inc = (&since_release_reg) ? since_release_reg : since_release_reg + 1'b1;

    always_comb
    begin
        pressed_next       = pressed_reg;
        pending_next       = pending_reg;
        since_press_next   = since_press_reg;
        since_release_next = since_release_reg;
        forward_next       = forward_reg;
        release_next       = release_reg;
        held_next          = held_reg;
        res_valid_next     = res_valid_reg && !res.ready;

        if (accept)
        begin
            forward_next   = 1'b0;
            release_next   = 1'b0;
            res_valid_next = 1'b1;

            case (bcrf_pkg::op_t'(ev.op))
                bcrf_pkg::OP_TICK:
                begin
                    // ticks ignore injected; release timer runs only while pending
                    since_press_next = press_inc;
                    if (pending_reg)
                    begin
                        since_release_next = release_inc;
                        if (regs.bypass)
                        begin
                            pending_next = 1'b0;
                        end
                        else if (CMP_W'(release_inc) >= CMP_W'(regs.recontact_time))
                        begin
                            pending_next = 1'b0;
                            if (pressed_reg)
                            begin
                                pressed_next = 1'b0;
                                release_next = 1'b1;
                            end
                        end
                    end
                end
                bcrf_pkg::OP_DOWN:
                begin
                    if (ev.injected || regs.bypass)
                    begin
                        forward_next = 1'b1;
                    end
                    else if (pending_reg)
                    begin
                        pending_next = 1'b0;    // recontact, swallowed
                    end
                    else if (!pressed_reg)
                    begin
                        pressed_next     = 1'b1;
                        since_press_next = '0;
                        forward_next     = 1'b1;
                    end
                end
                bcrf_pkg::OP_UP:
                begin
                    if (ev.injected || regs.bypass)
                    begin
                        forward_next = 1'b1;
                    end
                    else if (pressed_reg &&
                             (CMP_W'(since_press_reg) >= CMP_W'(regs.chatter_time)))
                    begin
                        pending_next       = 1'b1;
                        since_release_next = '0;
                    end
                end
                default:
                begin
                    forward_next = 1'b1;    // other events pass through
                end
            endcase

            held_next = pressed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg       <= 1'b0;
            pending_reg       <= 1'b0;
            since_press_reg   <= '0;
            since_release_reg <= '0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            pressed_reg       <= pressed_next;
            pending_reg       <= pending_next;
            since_press_reg   <= since_press_next;
            since_release_reg <= since_release_next;
            res_valid_reg     <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        forward_reg <= forward_next;
        release_reg <= release_next;
        held_reg    <= held_next;
    end

    // a pending release always belongs to a logical press
    `BCRF_ASSERT_SAME(a_pending_pressed, pending_reg, pressed_reg)
    // a synthesised release leaves the button released
    `BCRF_ASSERT_SAME(a_release_held, res_valid_reg && release_reg, !held_reg)
    // an empty output register never blocks the input
    `BCRF_ASSERT_SAME(a_ready_empty, !res_valid_reg, ev.ready)
    // a forwarded plain down from released state leaves the button held
    `BCRF_ASSERT_NEXT(a_down_press,
        accept && (ev.op == bcrf_pkg::OP_DOWN) && !ev.injected && !regs.bypass
            && !pressed_reg, pressed_reg && held_reg && forward_reg)

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the button chatter and recontact filter.
// Depends on bcrf_pkg, the bcrf channel interfaces and the filter RTL.

module testbench;

    localparam int HALF_PERIOD  = 6;     // 12 ns clock
    localparam int RESET_CYCLES = 3;
    localparam int RANDOM_ITEMS = 760;   // rough size of the random part
    localparam int SETTLE       = 3;     // extra wait after the last owed result, as results are registered
    localparam int IDLE_LIMIT   = 2000;  // cycles with no transfer before giving up

    // index past the register list, must be ignored by the block
    localparam logic [bcrf_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [bcrf_pkg::CFG_W-1:0]     CNT_MAX   = '1;

    typedef struct packed {
        logic forward;
        logic release_now;
        logic held;
    } filter_res_t;

    logic clk;
    logic rst_n;

    bcrf_evt_if ev_if ();
    bcrf_res_if res_if ();
    bcrf_cfg_if cfg_if ();

    button_chatter_recontact_filter u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .ev    (ev_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    // ------------------------------------------------------------------
    // Own copy of the filter: settings and state, updated on each transfer
    // ------------------------------------------------------------------
    logic [bcrf_pkg::CFG_W-1:0] m_chatter;
    logic [bcrf_pkg::CFG_W-1:0] m_recontact;
    logic                       m_bypass;
    logic                       m_pressed;
    logic                       m_pending;      // release waiting for recontact
    logic [bcrf_pkg::CFG_W-1:0] m_since_press;
    logic [bcrf_pkg::CFG_W-1:0] m_since_release;

    filter_res_t due_q[$];           // results still owed by the block

    int events_sent;
    int results_seen;
    int releases_seen;
    int reg_writes;
    int fail_count;
    int burst_left;
    int noise_pct;
    int idle_cycles;

    // receiver stall pattern state
    int stall_mode;
    int stall_left;
    int stall_phase;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    function automatic logic [bcrf_pkg::CFG_W-1:0] sat_up(logic [bcrf_pkg::CFG_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // Advance the filter copy by one event and return what the block owes.
    function automatic filter_res_t filter_event(bcrf_pkg::op_t op, logic inj);
        filter_res_t r;
        r = '0;
        if (op == bcrf_pkg::OP_TICK)
        begin
            // ticks are never forwarded; injected flag has no meaning here
            m_since_press = sat_up(m_since_press);
            if (m_pending)
            begin
                m_since_release = sat_up(m_since_release);
                if (m_bypass)
                    m_pending = 1'b0;          // timer lost in bypass, no release
                else if (m_since_release >= m_recontact)
                begin
                    m_pending = 1'b0;
                    if (m_pressed)
                    begin
                        m_pressed     = 1'b0;
                        r.release_now = 1'b1;
                    end
                end
            end
        end
        else if (op == bcrf_pkg::OP_OTHER || inj || m_bypass)
            r.forward = 1'b1;                  // passes untouched
        else if (op == bcrf_pkg::OP_DOWN)
        begin
            if (m_pending)
                m_pending = 1'b0;              // recontact: cancel, swallow
            else if (!m_pressed)
            begin
                m_pressed     = 1'b1;
                m_since_press = '0;
                r.forward     = 1'b1;
            end
        end
        else
        begin
            // up: always swallowed, opens a pending release once held long enough
            if (m_pressed && m_since_press >= m_chatter)
            begin
                m_pending       = 1'b1;
                m_since_release = '0;
            end
        end
        r.held = m_pressed;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: register writes, event transfers and result checks.
    // Results are checked before the new event is queued.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        filter_res_t want;
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
            begin
                case (cfg_if.index)
                    bcrf_pkg::REG_CHATTER:   m_chatter   = cfg_if.data;
                    bcrf_pkg::REG_RECONTACT: m_recontact = cfg_if.data;
                    bcrf_pkg::REG_BYPASS:    m_bypass    = cfg_if.data[0];
                    default:                 ;           // spare index ignored
                endcase
                reg_writes++;
            end
            if (res_if.valid && res_if.ready)
            begin
                results_seen++;
                if (res_if.release_now === 1'b1)
                    releases_seen++;
                if (due_q.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = due_q.pop_front();
                    if (res_if.forward !== want.forward)
                    begin
                        $error("forward: expected %0b, got %0b", want.forward, res_if.forward);
                        fail_count++;
                    end
                    if (res_if.release_now !== want.release_now)
                    begin
                        $error("release_now: expected %0b, got %0b",
                               want.release_now, res_if.release_now);
                        fail_count++;
                    end
                    if (res_if.held !== want.held)
                    begin
                        $error("held: expected %0b, got %0b", want.held, res_if.held);
                        fail_count++;
                    end
                end
            end
            if (ev_if.valid && ev_if.ready)
                due_q.push_back(filter_event(bcrf_pkg::op_t'(ev_if.op), ev_if.injected));
        end
    end

    // ------------------------------------------------------------------
    // Receiver: switches between free flow, coin-flip, periodic and heavy stalls
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 150);
        end
        else
            stall_left--;
        stall_phase++;
        case (stall_mode)
            0:       res_if.ready <= 1'b1;
            1:       res_if.ready <= 1'($urandom_range(0, 1));
            2:       res_if.ready <= (stall_phase % 4) != 0;
            default: res_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transfer means the block is stuck
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (ev_if.valid && ev_if.ready) || (res_if.valid && res_if.ready)
                   || (cfg_if.valid && cfg_if.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: %0d cycles without a transfer", idle_cycles);
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One event transfer; bursts of random length separated by random gaps.
    // valid stays high between back-to-back events.
    task automatic send_event(bcrf_pkg::op_t op, logic inj);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                ev_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        ev_if.valid    <= 1'b1;
        ev_if.op       <= op;
        ev_if.injected <= inj;
        do
            @(posedge clk);
        while (!ev_if.ready);
        events_sent++;
    endtask

    // Stop sending and wait for every owed result to come back.
    task automatic stop_and_drain();
        ev_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [bcrf_pkg::CFG_IDX_W-1:0] idx,
                             logic [bcrf_pkg::CFG_W-1:0] data);
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        cfg_if.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(int chatter, int recontact, logic byp);
        stop_and_drain();
        write_reg(bcrf_pkg::REG_CHATTER, chatter[bcrf_pkg::CFG_W-1:0]);
        write_reg(bcrf_pkg::REG_RECONTACT, recontact[bcrf_pkg::CFG_W-1:0]);
        write_reg(bcrf_pkg::REG_BYPASS, {{(bcrf_pkg::CFG_W-1){1'b0}}, byp});
    endtask

    task automatic maybe_noise();
        if ($urandom_range(0, 99) < noise_pct)
            send_event(bcrf_pkg::op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_ticks(int n);
        repeat (n)
        begin
            maybe_noise();
            send_event(bcrf_pkg::OP_TICK, 1'($urandom_range(0, 1)));
        end
    endtask

    // A press and release with bounces, timed around the current thresholds.
    task automatic press_cycle();
        int hold;
        int wait_ticks;
        send_event(bcrf_pkg::OP_DOWN, 1'b0);
        if ($urandom_range(0, 3) == 0)
            send_event(bcrf_pkg::OP_DOWN, 1'b0);                 // duplicate down
        if ($urandom_range(0, 2) == 0)
        begin
            send_ticks($urandom_range(0, m_chatter));  // early bounce
            send_event(bcrf_pkg::OP_UP, 1'b0);
        end
        hold = int'(m_chatter) + int'($urandom_range(0, 2)) - 1;
        send_ticks(hold < 0 ? 0 : hold);
        maybe_noise();
        send_event(bcrf_pkg::OP_UP, 1'b0);
        if ($urandom_range(0, 2) == 0)
        begin
            send_ticks($urandom_range(0, m_recontact)); // recontact inside window
            send_event(bcrf_pkg::OP_DOWN, 1'b0);
            if ($urandom_range(0, 1) == 1)
            begin
                send_ticks($urandom_range(0, 2));
                send_event(bcrf_pkg::OP_UP, 1'b0);
            end
        end
        wait_ticks = int'(m_recontact) + int'($urandom_range(0, 2)) - 1;
        send_ticks(wait_ticks < 0 ? 0 : wait_ticks);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset thresholds: other event, unmatched up, first down, duplicate down, too-short press.
    task automatic test_reset_defaults();
        noise_pct = 0;
        send_event(bcrf_pkg::OP_OTHER, 1'b0);
        send_event(bcrf_pkg::OP_UP, 1'b0);
        send_event(bcrf_pkg::OP_DOWN, 1'b0);
        send_event(bcrf_pkg::OP_DOWN, 1'b0);
        send_event(bcrf_pkg::OP_UP, 1'b0);
    endtask

    // Short thresholds: accepted up, recontact cancel, confirmed release, injected events.
    task automatic test_chatter_recontact();
        set_config(2, 2, 1'b0);
        send_ticks(2);
        send_event(bcrf_pkg::OP_UP, 1'b0);
        send_event(bcrf_pkg::OP_DOWN, 1'b0);
        send_event(bcrf_pkg::OP_UP, 1'b0);
        send_ticks(2);
        send_event(bcrf_pkg::OP_DOWN, 1'b1);
        send_event(bcrf_pkg::OP_UP, 1'b1);
        send_event(bcrf_pkg::OP_OTHER, 1'b1);
        send_event(bcrf_pkg::OP_TICK, 1'b1);
    endtask

    // Zero recontact time confirms on the first tick.
    task automatic test_recontact_zero();
        set_config(0, 0, 1'b0);
        send_event(bcrf_pkg::OP_DOWN, 1'b0);
        send_event(bcrf_pkg::OP_UP, 1'b0);
        send_event(bcrf_pkg::OP_TICK, 1'b0);
    endtask

    // A tick in bypass drops a pending release without emitting it.
    task automatic test_bypass_drop();
        set_config(0, 3, 1'b0);
        send_event(bcrf_pkg::OP_DOWN, 1'b0);
        send_event(bcrf_pkg::OP_UP, 1'b0);
        stop_and_drain();
        write_reg(bcrf_pkg::REG_BYPASS, 10'd1);
        send_event(bcrf_pkg::OP_TICK, 1'b0);
        send_event(bcrf_pkg::OP_DOWN, 1'b0);
        send_event(bcrf_pkg::OP_UP, 1'b0);
        stop_and_drain();
        write_reg(bcrf_pkg::REG_BYPASS, 10'd0);
        send_ticks(2);
    endtask

    // Writes past the register list change nothing.
    task automatic test_spare_index();
        stop_and_drain();
        write_reg(REG_SPARE, 10'h3FF);
        write_reg(REG_SPARE, 10'h000);
        press_cycle();
    endtask

    // Top chatter threshold: the press counter runs into saturation and stays there.
    task automatic test_saturation();
        noise_pct = 0;
        set_config(1023, 4, 1'b0);
        send_event(bcrf_pkg::OP_DOWN, 1'b0);
        send_ticks(1022);
        send_event(bcrf_pkg::OP_UP, 1'b0);   // one tick short of the chatter time
        send_ticks(3);                        // press counter pinned at all ones
        send_event(bcrf_pkg::OP_UP, 1'b0);   // now accepted
        send_ticks(5);
        send_event(bcrf_pkg::OP_DOWN, 1'b0);
        send_event(bcrf_pkg::OP_UP, 1'b0);   // press counter still low: swallowed
    endtask

    // Random phases of mostly well-formed presses, with noise and broken runs.
    task automatic test_random_traffic();
        int start_count;
        int phase_end;
        int chatter;
        int recontact;
        int spare_data;
        start_count = events_sent;
        while (events_sent - start_count < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0:       chatter = 0;
                1:       chatter = 1;
                5:       chatter = $urandom_range(7, 12);
                default: chatter = $urandom_range(2, 6);
            endcase
            case ($urandom_range(0, 5))
                0:       recontact = 0;
                1:       recontact = 1;
                5:       recontact = $urandom_range(7, 12);
                default: recontact = $urandom_range(2, 6);
            endcase
            set_config(chatter, recontact, $urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0)
            begin
                spare_data = $urandom_range(0, 1023);
                write_reg(REG_SPARE, spare_data[bcrf_pkg::CFG_W-1:0]);
            end
            noise_pct = $urandom_range(0, 10);
            phase_end = events_sent + $urandom_range(80, 220);
            while (events_sent < phase_end && events_sent - start_count < RANDOM_ITEMS)
            begin
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 8))
                        send_event(bcrf_pkg::op_t'($urandom_range(0, 3)),
                                   1'($urandom_range(0, 1)));
                else
                    press_cycle();
                if ($urandom_range(0, 30) == 0)
                    stop_and_drain();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        ev_if.valid    = 1'b0;
        ev_if.op       = bcrf_pkg::OP_TICK;
        ev_if.injected = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = bcrf_pkg::REG_CHATTER;
        cfg_if.data    = '0;
        res_if.ready   = 1'b0;

        m_chatter       = bcrf_pkg::CHATTER_RESET;
        m_recontact     = bcrf_pkg::RECONTACT_RESET;
        m_bypass        = 1'b0;
        m_pressed       = 1'b0;
        m_pending       = 1'b0;
        m_since_press   = '0;
        m_since_release = '0;

        events_sent   = 0;
        results_seen  = 0;
        releases_seen = 0;
        reg_writes    = 0;
        fail_count    = 0;
        burst_left    = 0;
        noise_pct     = 0;
        idle_cycles   = 0;
        stall_mode    = 0;
        stall_left    = 0;
        stall_phase   = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_chatter_recontact();
        test_recontact_zero();
        test_bypass_drop();
        test_spare_index();
        test_saturation();
        test_random_traffic();

        stop_and_drain();
        if (due_q.size() != 0)
        begin
            $error("%0d results never arrived", due_q.size());
            fail_count += due_q.size();
        end

        $display("Covered %0d events and %0d results, %0d of them synthesised releases,",
                 events_sent, results_seen, releases_seen);
        $display("over %0d register writes from zero thresholds to 1023, bypass on and off.",
                 reg_writes);
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
